[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the grid neighbour search.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising edge outside reset.
`define UKN_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");
// Next-cycle implication, checked at every rising edge outside reset.
`define UKN_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");
`else
`define UKN_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define UKN_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[design/ukn_pkg.sv]
// ----------------------------------------------------------------------------
// Grid neighbour search package
// Widths, register indexes and the effective configuration type.
// ----------------------------------------------------------------------------
package ukn_pkg;

	localparam int Q_W      = 32;             // Q16.16 coordinates
	localparam int STEP_W   = 31;             // grid step register
	localparam int CNT_W    = 17;             // point count register
	localparam int K_W      = 5;              // neighbour count field
	localparam int OUT_IDX_W = 16;            // delivered index width
	localparam int IDX_W    = CNT_W;          // internal grid index
	localparam int PROD_W   = IDX_W + STEP_W; // index times step
	localparam int GV_W     = PROD_W + 2;     // signed grid values
	localparam int NUM_W    = Q_W + 3;        // 2*d + step
	localparam int DEN_W    = STEP_W + 1;     // 2*step
	localparam int DSH_W    = DEN_W + IDX_W - 1;
	localparam int DCNT_W   = $clog2(IDX_W);
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_START  = 2'd0,
		REG_GRID_STEP   = 2'd1,
		REG_POINT_COUNT = 2'd2
	} reg_idx_t;

	// Configuration after the zero-step and count-range corrections.
	typedef struct packed {
		logic [Q_W-1:0]    start;
		logic [STEP_W-1:0] step;
		logic [CNT_W-1:0]  count;
	} cfg_t;

endpackage

[design/ukn_cfg.sv]
// ----------------------------------------------------------------------------
// Grid configuration registers
// Holds start, step and point count and presents their effective values.
// ----------------------------------------------------------------------------
module ukn_cfg import ukn_pkg::*; #(
	parameter int unsigned MAX_POINTS = 65536
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [Q_W-1:0]       wr_data,
	output cfg_t                 eff
);

	logic [Q_W-1:0]    start_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			step_q  <= STEP_W'(65536);
			count_q <= CNT_W'(1);
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_GRID_START:  start_q <= wr_data;
				REG_GRID_STEP:   step_q  <= wr_data[STEP_W-1:0];
				REG_POINT_COUNT: count_q <= wr_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		eff.start = start_q;
		eff.step  = (step_q == '0) ? STEP_W'(1) : step_q;
		if (count_q == '0)
			eff.count = CNT_W'(1);
		else if (32'(count_q) > MAX_POINTS)
			eff.count = CNT_W'(MAX_POINTS);
		else
			eff.count = count_q;
	end

endmodule

[design/ukn_div.sv]
// ----------------------------------------------------------------------------
// Iterative divider
// Shift-subtract division giving one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ukn_div import ukn_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] numer,
	input  logic [DEN_W-1:0] denom,
	output logic             done,
	output logic [IDX_W-1:0] quot
);

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] step_q;
	logic [NUM_W-1:0]  rem_q;
	logic [DSH_W-1:0]  dsh_q;
	logic [IDX_W-1:0]  quot_q;
	logic              ge;

	// The quotient is known to fit in IDX_W bits, so the divisor starts
	// shifted up by IDX_W-1 places and the remainder always stays below twice that.
	assign ge = {{(DSH_W-NUM_W){1'b0}}, rem_q} >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + DCNT_W'(1);
				if (step_q == DCNT_W'(IDX_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= numer;
			dsh_q <= {denom, {(IDX_W-1){1'b0}}};
		end else if (busy_q) begin
			if (ge)
				rem_q <= rem_q - dsh_q[NUM_W-1:0];
			dsh_q  <= dsh_q >> 1;
			quot_q <= {quot_q[IDX_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

[design/uniform_grid_k_nearest_index_top.sv]
// ----------------------------------------------------------------------------
// Uniform grid k-nearest index search
// Finds the k grid indices nearest to a query coordinate on a uniform grid.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake              Payload
//  -------  ---------------------  -------------------------------------------
//  in       in_valid / in_stall    query_value, neighbour_count, want_sorted
//  out      out_valid / out_stall  grid_index, last_of_run, bad_count
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  A bad count gives a single error item; the unsorted full list skips the
//  search. Other queries pass a multiply for the last grid value, a clamp
//  test, the divider (17 quotient bits, then done), a multiply for the start
//  value, then one item per cycle unless the output stalls; a query clamped
//  to an end skips the divider. A stalled output holds the sequencer. Reset
//  is asynchronous and restores the default grid; no clearing pass.
//
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uniform_grid_k_nearest_index_top import ukn_pkg::*; #(
	parameter int unsigned MAX_K      = 16,
	parameter int unsigned MAX_POINTS = 65536
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Query channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [Q_W-1:0]       query_value,
	input  logic [K_W-1:0]       neighbour_count,
	input  logic                 want_sorted,
	// Result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [OUT_IDX_W-1:0] grid_index,
	output logic                 last_of_run,
	output logic                 bad_count,
	// Configuration channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [Q_W-1:0]       cfg_data
);

	// One-hot sequencer states.
	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_EDGE  = 9'b000000010,
		S_CLAMP = 9'b000000100,
		S_DIV   = 9'b000001000,
		S_MUL   = 9'b000010000,
		S_INIT  = 9'b000100000,
		S_NEAR  = 9'b001000000,
		S_LIST  = 9'b010000000,
		S_BAD   = 9'b100000000
	} state_t;

	// Magnitude of a signed grid-value difference.
	function automatic logic [GV_W-1:0] mag(input logic signed [GV_W-1:0] v);
		mag = v[GV_W-1] ? GV_W'(-v) : GV_W'(v);
	endfunction

	state_t state_q;
	cfg_t   cfg;

	logic [Q_W-1:0]       x_q;
	logic [K_W-1:0]       k_q;
	logic [K_W-1:0]       cnt_q;
	logic [IDX_W-1:0]     q_q;
	logic [IDX_W-1:0]     lo_q;
	logic [IDX_W-1:0]     hi_q;
	logic [PROD_W-1:0]    prod_q;
	logic signed [GV_W-1:0] glo_m_q;  // grid value just left of the window
	logic signed [GV_W-1:0] ghi_p_q;  // grid value just right of the window

	logic                 out_valid_q;
	logic [OUT_IDX_W-1:0] out_idx_q;
	logic                 out_last_q;
	logic                 out_bad_q;

	logic                 accept;
	logic                 slot_free;
	logic                 k_bad;
	logic                 k_all;
	logic [IDX_W-1:0]     n_last;
	logic [IDX_W-1:0]     mul_a;
	logic signed [GV_W-1:0] x_ext;
	logic signed [GV_W-1:0] start_ext;
	logic signed [GV_W-1:0] step_ext;
	logic signed [GV_W-1:0] prod_ext;
	logic signed [GV_W-1:0] gv_edge;
	logic                 below;
	logic                 above;
	logic [Q_W:0]         diff;
	logic [NUM_W-1:0]     div_num;
	logic [DEN_W-1:0]     div_den;
	logic                 div_start;
	logic                 div_done;
	logic [IDX_W-1:0]     div_quot;
	logic [GV_W-1:0]      d_lo;
	logic [GV_W-1:0]      d_hi;
	logic                 take_hi;
	logic                 run_last;
	logic                 emit;
	logic [IDX_W-1:0]     emit_idx;
	logic                 emit_last;
	logic                 emit_bad;

	// Configuration registers; writes are always taken.
	assign cfg_ready = 1'b1;

	ukn_cfg #(
		.MAX_POINTS (MAX_POINTS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.eff      (cfg)
	);

	// A new query is taken only while the sequencer is idle.
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	// Count checks made as the query is accepted.
	assign k_bad = (neighbour_count == '0) ||
		({{(CNT_W-K_W){1'b0}}, neighbour_count} > cfg.count) ||
		(32'(neighbour_count) > MAX_K);
	assign k_all = ({{(CNT_W-K_W){1'b0}}, neighbour_count} == cfg.count) && !want_sorted;

	assign n_last = cfg.count - IDX_W'(1);

	// The single multiplier: last index times step in S_EDGE, otherwise the
	// nearest index times step.
	assign mul_a = (state_q == S_EDGE) ? n_last : q_q;

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a) * PROD_W'(cfg.step);
	end

	assign x_ext     = GV_W'($signed(x_q));
	assign start_ext = GV_W'($signed(cfg.start));
	assign step_ext  = $signed({{(GV_W-STEP_W){1'b0}}, cfg.step});
	assign prod_ext  = $signed({{(GV_W-PROD_W){1'b0}}, prod_q});
	assign gv_edge   = start_ext + prod_ext;

	// Clamp tests, valid in S_CLAMP where prod_q holds (n-1)*step.
	assign below = $signed(x_q) <= $signed(cfg.start);
	assign above = x_ext >= gv_edge;

	// Between the ends the offset is positive and below 2^32; the divider
	// rounds half up by dividing 2*d + step by 2*step.
	assign diff    = {x_q[Q_W-1], x_q} - {cfg.start[Q_W-1], cfg.start};
	assign div_num = {2'b00, diff[Q_W-1:0], 1'b0} + {{(NUM_W-STEP_W){1'b0}}, cfg.step};
	assign div_den = {cfg.step, 1'b0};
	assign div_start = (state_q == S_CLAMP) && !below && !above;

	ukn_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (div_num),
		.denom  (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Window growth: an end of the grid forces the direction, otherwise the
	// nearer neighbour wins and a tie goes right.
	assign d_lo = mag(x_ext - glo_m_q);
	assign d_hi = mag(ghi_p_q - x_ext);

	always_comb begin
		if (lo_q == '0)
			take_hi = 1'b1;
		else if (hi_q == n_last)
			take_hi = 1'b0;
		else
			take_hi = !(d_lo < d_hi);
	end

	assign run_last  = (cnt_q + K_W'(1)) == k_q;
	assign slot_free = !out_valid_q || !out_stall;

	// Item produced by the current state, if any.
	always_comb begin
		emit      = 1'b0;
		emit_idx  = '0;
		emit_last = 1'b0;
		emit_bad  = 1'b0;
		case (state_q)
			S_INIT: begin
				emit      = 1'b1;
				emit_idx  = q_q;
				emit_last = (k_q == K_W'(1));
			end
			S_NEAR: begin
				emit      = 1'b1;
				emit_idx  = take_hi ? (hi_q + IDX_W'(1)) : (lo_q - IDX_W'(1));
				emit_last = run_last;
			end
			S_LIST: begin
				emit      = 1'b1;
				emit_idx  = IDX_W'(cnt_q);
				emit_last = run_last;
			end
			S_BAD: begin
				emit      = 1'b1;
				emit_last = 1'b1;
				emit_bad  = 1'b1;
			end
			default: ;
		endcase
	end

	// Sequencer and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit && slot_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						if (k_bad)
							state_q <= S_BAD;
						else if (k_all)
							state_q <= S_LIST;
						else
							state_q <= S_EDGE;
					end
				end
				S_EDGE:  state_q <= S_CLAMP;
				S_CLAMP: state_q <= (below || above) ? S_MUL : S_DIV;
				S_DIV: begin
					if (div_done)
						state_q <= S_MUL;
				end
				S_MUL:   state_q <= S_INIT;
				S_INIT: begin
					if (slot_free) begin
						cnt_q   <= K_W'(1);
						state_q <= (k_q == K_W'(1)) ? S_IDLE : S_NEAR;
					end
				end
				S_NEAR, S_LIST: begin
					if (slot_free) begin
						cnt_q <= cnt_q + K_W'(1);
						if (run_last)
							state_q <= S_IDLE;
					end
				end
				S_BAD: begin
					if (slot_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Query, window and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= query_value;
			k_q <= neighbour_count;
		end

		if (state_q == S_CLAMP)
			q_q <= below ? '0 : n_last;
		else if (state_q == S_DIV && div_done)
			q_q <= div_quot;

		// prod_q holds q*step here; the window opens on the nearest index.
		if (state_q == S_INIT) begin
			lo_q    <= q_q;
			hi_q    <= q_q;
			glo_m_q <= gv_edge - step_ext;
			ghi_p_q <= gv_edge + step_ext;
		end else if (state_q == S_NEAR && slot_free) begin
			if (take_hi) begin
				hi_q    <= hi_q + IDX_W'(1);
				ghi_p_q <= ghi_p_q + step_ext;
			end else begin
				lo_q    <= lo_q - IDX_W'(1);
				glo_m_q <= glo_m_q - step_ext;
			end
		end

		if (emit && slot_free) begin
			out_idx_q  <= emit_idx[OUT_IDX_W-1:0];
			out_last_q <= emit_last;
			out_bad_q  <= emit_bad;
		end
	end

	assign out_valid   = out_valid_q;
	assign grid_index  = out_idx_q;
	assign last_of_run = out_last_q;
	assign bad_count   = out_bad_q;

	// An error item is always the last of its run.
	`UKN_ASSERT_IMP(a_bad_is_last, clk, arst_n, out_valid && bad_count, last_of_run)
	// While the window grows it stays ordered and inside the grid.
	`UKN_ASSERT_IMP(a_window_in_grid, clk, arst_n, state_q == S_NEAR, (lo_q <= hi_q) && (hi_q <= n_last))
	// The divider only finishes while the sequencer waits for it.
	`UKN_ASSERT_IMP(a_div_done_in_div, clk, arst_n, div_done, state_q == S_DIV)
	// An accepted query always leaves the idle state.
	`UKN_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, state_q != S_IDLE)

endmodule

[tb/tb_uniform_grid_k_nearest_index_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the uniform grid k-nearest index search
// Drives queries through several grid settings, predicts every index that
// each query should return and checks the results in order, field by field.
// ----------------------------------------------------------------------------

module tb_uniform_grid_k_nearest_index_top import ukn_pkg::*;;

	// One result item as the block delivers it.
	typedef struct packed {
		logic [OUT_IDX_W-1:0] idx;
		logic                 last;
		logic                 bad;
	} grid_hit_t;

	// The scoreboard keeps its own copy of the grid registers and works out,
	// for every accepted query, the full list of indices that should follow.
	class neighbour_scoreboard;
		localparam longint MAX_NEIGHBOURS = 16;
		localparam longint MAX_GRID       = 65536;

		grid_hit_t             hits_due[$];
		int unsigned           faults;
		logic signed [Q_W-1:0] start_r;
		logic [STEP_W-1:0]     step_r;
		logic [CNT_W-1:0]      count_r;

		function new();
			start_r = '0;
			step_r  = STEP_W'(65536);
			count_r = CNT_W'(1);
			faults  = 0;
		endfunction

		function void set_reg(reg_idx_t which, logic [Q_W-1:0] data);
			case (which)
				REG_GRID_START:  start_r = data;
				REG_GRID_STEP:   step_r  = data[STEP_W-1:0];
				REG_POINT_COUNT: count_r = data[CNT_W-1:0];
				default: ;
			endcase
		endfunction

		// Points in use: zero counts as one, and the count saturates.
		function longint points();
			if (count_r == 0)
				return 1;
			if (count_r > MAX_GRID)
				return MAX_GRID;
			return longint'(count_r);
		endfunction

		// A zero step is taken as the smallest step.
		function longint pitch();
			return (step_r == 0) ? 1 : longint'(step_r);
		endfunction

		function longint coord(longint i);
			return longint'(start_r) + i * pitch();
		endfunction

		function grid_hit_t make_hit(longint i, bit fin, bit err);
			grid_hit_t h;
			h.idx  = i[OUT_IDX_W-1:0];
			h.last = fin;
			h.bad  = err;
			return h;
		endfunction

		function int pending();
			return hits_due.size();
		endfunction

		function void note_query(logic [Q_W-1:0] q, logic [K_W-1:0] k, logic sorted);
			longint x, n, s, want, lo, hi, pick, dl, dh;
			x    = longint'($signed(q));
			n    = points();
			s    = pitch();
			want = longint'(k);
			if (want == 0 || want > n || want > MAX_NEIGHBOURS) begin
				hits_due.push_back(make_hit(0, 1'b1, 1'b1));
				return;
			end
			// Every point asked for without sorting: plain ascending order.
			if (want == n && !sorted) begin
				for (longint i = 0; i < want; i++)
					hits_due.push_back(make_hit(i, i == want - 1, 1'b0));
				return;
			end
			// Nearest index: clamp at both ends, otherwise round half up.
			if (x <= coord(0))
				lo = 0;
			else if (x >= coord(n - 1))
				lo = n - 1;
			else
				lo = (2 * (x - longint'(start_r)) + s) / (2 * s);
			hi = lo;
			hits_due.push_back(make_hit(lo, want == 1, 1'b0));
			// Grow the window toward the closer neighbour; a tie goes right.
			for (longint i = 1; i < want; i++) begin
				if (lo == 0) begin
					hi++;
					pick = hi;
				end else if (hi == n - 1) begin
					lo--;
					pick = lo;
				end else begin
					dl = x - coord(lo - 1);
					dh = coord(hi + 1) - x;
					if (dl < 0)
						dl = -dl;
					if (dh < 0)
						dh = -dh;
					if (dl < dh) begin
						lo--;
						pick = lo;
					end else begin
						hi++;
						pick = hi;
					end
				end
				hits_due.push_back(make_hit(pick, i == want - 1, 1'b0));
			end
		endfunction

		// Printing stops after a hundred lines, counting does not.
		task report(string what);
			faults++;
			if (faults <= 100)
				$display("mismatch %0d: %s", faults, what);
		endtask

		task check_result(grid_hit_t got);
			grid_hit_t want;
			if (hits_due.size() == 0) begin
				report($sformatf("unexpected result: index %0d last %0b bad %0b",
					got.idx, got.last, got.bad));
				return;
			end
			want = hits_due.pop_front();
			if (got.idx != want.idx)
				report($sformatf("grid_index %0d, expected %0d", got.idx, want.idx));
			if (got.last != want.last)
				report($sformatf("last_of_run %0b, expected %0b (index %0d)",
					got.last, want.last, want.idx));
			if (got.bad != want.bad)
				report($sformatf("bad_count %0b, expected %0b (index %0d)",
					got.bad, want.bad, want.idx));
		endtask
	endclass

	// Cycles in which nothing moves on any channel before the run is abandoned.
	// The slowest correct query needs its full search plus an output stall
	// burst and a sender gap between two handshakes, so this leaves a wide margin.
	localparam int QUIET_LIMIT = 4000;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [Q_W-1:0]       query_value;
	logic [K_W-1:0]       neighbour_count;
	logic                 want_sorted;
	logic                 out_valid;
	logic                 out_stall;
	logic [OUT_IDX_W-1:0] grid_index;
	logic                 last_of_run;
	logic                 bad_count;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [Q_W-1:0]       cfg_data;

	neighbour_scoreboard book;
	bit                  calm;        // set for the last part: no idling at all
	int                  quiet_cycles;

	uniform_grid_k_nearest_index_top u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.query_value     (query_value),
		.neighbour_count (neighbour_count),
		.want_sorted     (want_sorted),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.grid_index      (grid_index),
		.last_of_run     (last_of_run),
		.bad_count       (bad_count),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Presents one query and holds it until the block takes it. Valid is left
	// high afterwards: the next call either replaces the item in the same step
	// or opens a gap, so valid never drops and rises within one step.
	task automatic send_query(input logic [Q_W-1:0] q, input logic [K_W-1:0] k,
			input logic sorted);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid        <= 1'b1;
		query_value     <= q;
		neighbour_count <= k;
		want_sorted     <= sorted;
		do
			@(posedge clk);
		while (in_stall);
		book.note_query(q, k, sorted);
	endtask

	// Register writes follow one another with valid held high throughout.
	task automatic write_reg(input reg_idx_t which, input logic [Q_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= which;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		book.set_reg(which, data);
	endtask

	task automatic load_grid(input logic [Q_W-1:0] start_v, input logic [Q_W-1:0] step_v,
			input logic [Q_W-1:0] count_v);
		write_reg(REG_GRID_START, start_v);
		write_reg(REG_GRID_STEP, step_v);
		write_reg(REG_POINT_COUNT, count_v);
		cfg_valid <= 1'b0;
	endtask

	// Withdraws the query channel and waits for every outstanding result.
	// Every query gives at least one result, so an empty store means idle.
	task automatic settle();
		in_valid <= 1'b0;
		while (book.pending() != 0)
			@(posedge clk);
	endtask

	task automatic random_grid();
		logic [Q_W-1:0] start_v, step_v, count_v;
		case ($urandom_range(0, 5))
			0: start_v = 32'h8000_0000;
			1: start_v = 32'h7FFF_FFFF;
			2: start_v = '0;
			default: start_v = $urandom();
		endcase
		case ($urandom_range(0, 6))
			0: step_v = '0;
			1: step_v = 32'd1;
			2: step_v = 32'h7FFF_FFFF;
			3: step_v = 32'h0001_0000;
			4: step_v = $urandom_range(2, 8);
			5: step_v = $urandom_range(1, 1 << 20);
			default: step_v = $urandom();
		endcase
		// Mostly small grids, so that the whole-grid request turns up often.
		case ($urandom_range(0, 9))
			0: count_v = '0;
			1: count_v = 32'd1;
			2: count_v = 32'd65536;
			3: count_v = $urandom_range(65537, 131071);
			4: count_v = $urandom_range(21, 5000);
			default: count_v = $urandom_range(2, 20);
		endcase
		load_grid(start_v, step_v, count_v);
	endtask

	// Most queries sit on or near a grid point, with midpoints among them, so
	// that rounding and the tie rule of the window are both exercised.
	task automatic random_query();
		longint         n, s, pos, off, v;
		int             kmax;
		logic [Q_W-1:0] q;
		logic [K_W-1:0] k;
		n = book.points();
		s = book.pitch();
		case ($urandom_range(0, 9))
			0: q = $urandom();
			1: q = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			default: begin
				pos = longint'($urandom_range(0, 32'(n)));
				case ($urandom_range(0, 3))
					0: off = 0;
					1: off = s / 2;
					2: off = -((s + 1) / 2);
					default: off = longint'($urandom_range(0, 32'(2 * s))) - s;
				endcase
				v = book.coord(pos) + off;
				q = v[Q_W-1:0];
			end
		endcase
		kmax = (n < 16) ? int'(n) : 16;
		case ($urandom_range(0, 9))
			0: k = '0;
			1: k = K_W'($urandom_range(kmax + 1, 31));
			2: k = K_W'(kmax);
			default: k = K_W'($urandom_range(1, kmax));
		endcase
		send_query(q, k, 1'($urandom_range(0, 1)));
	endtask

	// Output stall comes in bursts, separated by quiet stretches of varying
	// length, and stops once the last part of the run has begun.
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				out_stall <= 1'b0;
				repeat ($urandom_range(0, 20)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			book.check_result('{idx: grid_index, last: last_of_run, bad: bad_count});
	end

	// Any handshake on any channel resets the count of quiet cycles.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		book            = new();
		calm            = 1'b0;
		arst_n          <= 1'b0;
		in_valid        <= 1'b0;
		query_value     <= '0;
		neighbour_count <= '0;
		want_sorted     <= 1'b0;
		cfg_valid       <= 1'b0;
		cfg_index       <= REG_GRID_START;
		cfg_data        <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset grid: a single point at zero. One index asked for is the
		// whole grid; zero or two indices are bad counts.
		send_query('0, 5'd1, 1'b0);
		send_query(32'h7FFF_FFFF, 5'd1, 1'b1);
		send_query('0, 5'd0, 1'b0);
		send_query(32'h8000_0000, 5'd2, 1'b1);
		settle();

		// Ten points at unit spacing from zero.
		load_grid('0, 32'h0001_0000, 32'd10);
		send_query(32'h8000_0000, 5'd3, 1'b0);   // clamped to the first point
		send_query(32'h7FFF_FFFF, 5'd3, 1'b0);   // clamped to the last point
		send_query(32'd163840, 5'd4, 1'b1);      // exact midpoint rounds up
		send_query(32'd163839, 5'd2, 1'b0);      // just below the midpoint
		send_query(32'd196608, 5'd3, 1'b0);      // on a point: equal neighbours
		send_query(32'd100000, 5'd10, 1'b0);     // whole grid, ascending
		send_query(32'd100000, 5'd10, 1'b1);     // whole grid, by distance
		send_query(32'd100000, 5'd11, 1'b0);     // more than the grid holds
		send_query(32'd100000, 5'd16, 1'b1);
		send_query(32'd100000, 5'd17, 1'b0);     // above the largest count
		send_query(32'd100000, 5'd31, 1'b1);
		settle();

		// Zero step after masking, and a count that saturates at the top.
		load_grid(32'h8000_0000, 32'h8000_0000, 32'h0001_FFFF);
		send_query(32'h7FFF_FFFF, 5'd16, 1'b0);
		send_query(32'h8000_0000, 5'd16, 1'b1);
		send_query(32'h8000_0064, 5'd5, 1'b1);
		settle();

		// Widest step with a zero count, which acts as a single point.
		load_grid(32'h7FFF_FFFF, 32'h7FFF_FFFF, '0);
		send_query(32'h7FFF_FFFF, 5'd1, 1'b1);
		send_query(32'h8000_0000, 5'd1, 1'b0);
		settle();

		// Random grids, each with a run of random queries.
		for (int phase = 0; phase < 8; phase++) begin
			if (phase == 7)
				calm = 1'b1;
			random_grid();
			for (int n = 0; n < 16; n++)
				random_query();
			settle();
		end

		// Room for any stray result to show itself.
		repeat (40) @(posedge clk);
		if (book.faults == 0 && book.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+design
design/ukn_pkg.sv
design/ukn_cfg.sv
design/ukn_div.sv
design/uniform_grid_k_nearest_index_top.sv
tb/tb_uniform_grid_k_nearest_index_top.sv
